/* rtl/lidar_point_camera_mask_filter_assert.svh */
// assertion macros used by the mask filter back end rtl
`ifndef LIDAR_POINT_CAMERA_MASK_FILTER_ASSERT_SVH
`define LIDAR_POINT_CAMERA_MASK_FILTER_ASSERT_SVH

// same-cycle implication
`define LPCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lpcm: assertion failed");

// next-cycle implication
`define LPCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lpcm: assertion failed");

`endif

/* rtl/lpcm_pkg.sv */
// ----------------------------------------------------------------------------
// lpcm_pkg
// Types and constants of the lidar point camera mask filter.
// ----------------------------------------------------------------------------
package lpcm_pkg;

  // input function codes
  localparam logic [1:0] FUNC_MASK  = 2'd0;
  localparam logic [1:0] FUNC_XFORM = 2'd1;
  localparam logic [1:0] FUNC_POINT = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_H = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_W   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_H   = 3'd6;

  localparam int XFORM_ENTRIES = 12;
  localparam logic signed [31:0] Q16_ONE = 32'sd65536;
  localparam logic signed [33:0] GATE_OFFSET = 34'sd13107;
  localparam logic signed [49:0] PROJ_LIMIT = 50'sd281474976710656;
  localparam logic [11:0] MASK_SIZE_RESET = 12'd2048;
  localparam int DIV_BITS = 48;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_MASK,
    OP_XFORM,
    OP_POINT
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [21:0]        index;
    logic signed [31:0] value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } item_t;

  typedef struct packed {
    item_t it;
    logic  gate;
    logic  neg_x;
    logic  neg_y;
  } side_t;

endpackage

/* rtl/lpcm_if.sv */
// ----------------------------------------------------------------------------
// lpcm_if
// Valid/ready channels of the lidar point camera mask filter.
// ----------------------------------------------------------------------------
interface lpcm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [21:0]        index;
  logic signed [31:0] value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, func, index, value, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, func, index, value, point_x, point_y, point_z,
                output ready);
endinterface

interface lpcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface lpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               masked;
  modport source (output valid, out_x, out_y, out_z, masked, input ready);
  modport sink (input valid, out_x, out_y, out_z, masked, output ready);
endinterface

/* rtl/lpcm_front.sv */
// ----------------------------------------------------------------------------
// lpcm_front
// Accepts input words, decodes the function and drops words that do nothing.
// ----------------------------------------------------------------------------
module lpcm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  lpcm_in_if.sink         in_i,
  input  logic            fifo_full_i,
  output logic            push_o,
  output lpcm_pkg::item_t item_o
);
  import lpcm_pkg::*;

  logic  valid_q;
  item_t item_q;
  item_t item_d;
  logic  keep_d;
  logic  accept;

  // decode
  always_comb begin
    item_d.index   = in_i.index;
    item_d.value   = in_i.value;
    item_d.point_x = in_i.point_x;
    item_d.point_y = in_i.point_y;
    item_d.point_z = in_i.point_z;
    item_d.op      = OP_POINT;
    keep_d         = 1'b0;
    case (in_i.func)
      FUNC_MASK: begin
        item_d.op = OP_MASK;
        keep_d    = 1'b1;
      end
      FUNC_XFORM: begin
        item_d.op = OP_XFORM;
        keep_d    = in_i.index < 22'(XFORM_ENTRIES);
      end
      FUNC_POINT: begin
        item_d.op = OP_POINT;
        keep_d    = 1'b1;
      end
      default: begin
        keep_d = 1'b0;
      end
    endcase
  end

  assign in_i.ready = !valid_q || !fifo_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = valid_q && !fifo_full_i;
  assign item_o     = item_q;

  // holding stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid && keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

/* rtl/lpcm_fifo.sv */
// ----------------------------------------------------------------------------
// lpcm_fifo
// Short queue between the decode front and the projection back end.
// ----------------------------------------------------------------------------
module lpcm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lpcm_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output lpcm_pkg::item_t item_o
);
  import lpcm_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  item_t         buf_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q;
  logic [PW-1:0] rd_q;
  logic [PW:0]   cnt_q;
  logic          do_pop;

  assign full_o  = cnt_q == (PW+1)'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = buf_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= item_i;
    end
  end

endmodule

/* rtl/lpcm_div.sv */
// ----------------------------------------------------------------------------
// lpcm_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// when the quotient reaches the projection limit.
// ----------------------------------------------------------------------------
module lpcm_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [62:0]                   num_i,
  input  logic [30:0]                   den_i,
  output logic [lpcm_pkg::DIV_BITS-1:0] quo_o,
  output logic                          ovf_o
);
  import lpcm_pkg::*;

  logic [30:0]         rem_q [DIV_BITS+1];
  logic [DIV_BITS-1:0] nq_q  [DIV_BITS+1];
  logic [30:0]         den_q [DIV_BITS+1];
  logic                ovf_q [DIV_BITS+1];

  // load: top bits form the first partial remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {16'd0, num_i[62:48]};
      nq_q[0]  <= num_i[DIV_BITS-1:0];
      den_q[0] <= den_i;
      ovf_q[0] <= {16'd0, num_i[62:48]} >= den_i;
    end
  end

  // one bit per stage
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    logic [31:0] trial;
    logic        ge;
    assign trial = {rem_q[k], nq_q[k][DIV_BITS-1]};
    assign ge    = trial >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? 31'(trial - {1'b0, den_q[k]}) : trial[30:0];
        nq_q[k+1]  <= {nq_q[k][DIV_BITS-2:0], ge};
        den_q[k+1] <= den_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = nq_q[DIV_BITS];
  assign ovf_o = ovf_q[DIV_BITS];

endmodule

/* rtl/lpcm_back.sv */
// ----------------------------------------------------------------------------
// lpcm_back
// Transform, gate, projection, bounds check and mask lookup pipeline.
// ----------------------------------------------------------------------------
`include "lidar_point_camera_mask_filter_assert.svh"

module lpcm_back #(
  parameter int MAX_MASK_WIDTH  = 2048,
  parameter int MAX_MASK_HEIGHT = 2048
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  lpcm_cfg_if.sink        cfg_i,
  input  logic            head_valid_i,
  input  lpcm_pkg::item_t head_i,
  output logic            pop_o,
  lpcm_out_if.source      out_o
);
  import lpcm_pkg::*;

  localparam int MASK_DEPTH = MAX_MASK_WIDTH * MAX_MASK_HEIGHT;
  localparam int AW = $clog2(MASK_DEPTH);
  localparam int DIV_LAT = DIV_BITS + 1;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] s);
    logic signed [31:0] r;
    if (s > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (s < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [31:0]        fx_q, fy_q;
  logic signed [31:0] cx_q, cy_q, sh_q;
  logic [11:0]        mw_q, mh_q;
  logic [12:0]        mw_lim, mh_lim;

  logic en;

  logic signed [31:0] xf_q [XFORM_ENTRIES];
  logic signed [31:0] pt [3];
  logic signed [63:0] prod_d [9];

  logic               vld1_q;
  item_t              it1_q;
  logic signed [63:0] prod1_q [9];
  logic signed [31:0] tr1_q [3];

  logic               vld2_q;
  item_t              it2_q;
  logic signed [31:0] cam2_q [3];
  logic signed [31:0] cam_d [3];

  logic               vld3_q;
  item_t              it3_q;
  logic               gate3_q;
  logic signed [63:0] numx3_q, numy3_q;
  logic [30:0]        cz3_q;
  logic               gate_d;
  logic signed [64:0] numx_d, numy_d;

  logic               vld4_q;
  side_t              side4_q;
  logic [62:0]        magx4_q, magy4_q;
  logic [30:0]        cz4_q;
  logic [63:0]        magx_d, magy_d;

  logic [DIV_LAT-1:0] dvld_q;
  side_t              dside_q [DIV_LAT];
  logic [DIV_BITS-1:0] qx, qy;
  logic               ovfx, ovfy;

  logic               vld5_q;
  item_t              it5_q;
  logic               gate5_q;
  logic signed [50:0] sumx5_q, sumy5_q;
  logic signed [49:0] magpx, magpy, valx, valy;

  logic               vld6_q;
  item_t              it6_q;
  logic               gate6_q;
  logic signed [34:0] col6_q, row6_q;
  logic signed [50:0] tx_d, ty_d;

  logic               vld7_q;
  item_t              it7_q;
  logic               look7_q;
  logic [AW-1:0]      addr7_q;
  logic               look_d;
  logic [25:0]        pix_d, idx_ext;

  logic               vld8_q;
  item_t              it8_q;
  logic               look8_q;
  logic               rd8_q;
  logic               mask_mem_q [MASK_DEPTH];

  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q, out_z_q;
  logic               masked_q;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= 32'(Q16_ONE);
      fy_q <= 32'(Q16_ONE);
      cx_q <= '0;
      cy_q <= '0;
      sh_q <= '0;
      mw_q <= MASK_SIZE_RESET;
      mh_q <= MASK_SIZE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FOCAL_X:  fx_q <= cfg_i.data;
        CFG_FOCAL_Y:  fy_q <= cfg_i.data;
        CFG_CENTER_X: cx_q <= cfg_i.data;
        CFG_CENTER_Y: cy_q <= cfg_i.data;
        CFG_SENSOR_H: sh_q <= cfg_i.data;
        CFG_MASK_W:   mw_q <= cfg_i.data[11:0];
        CFG_MASK_H:   mh_q <= cfg_i.data[11:0];
        default: begin
        end
      endcase
    end
  end

  // mask size limited to the store
  assign mw_lim = ({1'b0, mw_q} > 13'(MAX_MASK_WIDTH)) ? 13'(MAX_MASK_WIDTH) : {1'b0, mw_q};
  assign mh_lim = ({1'b0, mh_q} > 13'(MAX_MASK_HEIGHT)) ? 13'(MAX_MASK_HEIGHT) : {1'b0, mh_q};

  // whole pipeline advances while the output slot can take a word
  assign en    = !out_valid_q || out_o.ready;
  assign pop_o = head_valid_i && en;

  // transform entries, written in item order at the multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < XFORM_ENTRIES; i++) begin
        xf_q[i] <= (i == 0 || i == 5 || i == 10) ? Q16_ONE : 32'sd0;
      end
    end else if (pop_o && head_i.op == OP_XFORM) begin
      xf_q[head_i.index[3:0]] <= head_i.value;
    end
  end

  // stage 1: nine products
  assign pt[0] = head_i.point_x;
  assign pt[1] = head_i.point_y;
  assign pt[2] = head_i.point_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r*3+c] = 64'(xf_q[r*4+c]) * 64'(pt[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q <= head_i;
      for (int k = 0; k < 9; k++) begin
        prod1_q[k] <= prod_d[k];
      end
      for (int r = 0; r < 3; r++) begin
        tr1_q[r] <= xf_q[r*4+3];
      end
    end
  end

  // stage 2: floored sums with saturation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cam_d[r] = sat32(50'(prod1_q[r*3] >>> 16) + 50'(prod1_q[r*3+1] >>> 16)
                     + 50'(prod1_q[r*3+2] >>> 16) + 50'(tr1_q[r]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it2_q <= it1_q;
      for (int r = 0; r < 3; r++) begin
        cam2_q[r] <= cam_d[r];
      end
    end
  end

  // stage 3: gate and focal products
  assign gate_d = (cam2_q[2] > 32'sd0) && (34'(cam2_q[1]) > (34'(sh_q) - GATE_OFFSET));
  assign numx_d = $signed({33'd0, fx_q}) * 65'(cam2_q[0]);
  assign numy_d = $signed({33'd0, fy_q}) * 65'(cam2_q[1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      it3_q   <= it2_q;
      gate3_q <= gate_d;
      numx3_q <= numx_d[63:0];
      numy3_q <= numy_d[63:0];
      cz3_q   <= cam2_q[2][30:0];
    end
  end

  // stage 4: magnitude and sign for the dividers
  assign magx_d = numx3_q[63] ? 64'(-numx3_q) : 64'(numx3_q);
  assign magy_d = numy3_q[63] ? 64'(-numy3_q) : 64'(numy3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q.it    <= it3_q;
      side4_q.gate  <= gate3_q;
      side4_q.neg_x <= numx3_q[63];
      side4_q.neg_y <= numy3_q[63];
      magx4_q       <= magx_d[62:0];
      magy4_q       <= magy_d[62:0];
      cz4_q         <= cz3_q;
    end
  end

  // column and row dividers
  lpcm_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (magx4_q),
    .den_i (cz4_q),
    .quo_o (qx),
    .ovf_o (ovfx)
  );

  lpcm_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (magy4_q),
    .den_i (cz4_q),
    .quo_o (qy),
    .ovf_o (ovfy)
  );

  // item travels beside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      dside_q[0] <= side4_q;
      for (int j = 1; j < DIV_LAT; j++) begin
        dside_q[j] <= dside_q[j-1];
      end
    end
  end

  // stage 5: clamp, sign and principal point
  assign magpx = ovfx ? PROJ_LIMIT : 50'(qx);
  assign magpy = ovfy ? PROJ_LIMIT : 50'(qy);
  assign valx  = dside_q[DIV_LAT-1].neg_x ? -magpx : magpx;
  assign valy  = dside_q[DIV_LAT-1].neg_y ? -magpy : magpy;

  always_ff @(posedge clk_i) begin
    if (en) begin
      it5_q   <= dside_q[DIV_LAT-1].it;
      gate5_q <= dside_q[DIV_LAT-1].gate;
      sumx5_q <= 51'(valx) + 51'(cx_q);
      sumy5_q <= 51'(valy) + 51'(cy_q);
    end
  end

  // stage 6: pixel coordinates truncated toward zero
  assign tx_d = sumx5_q[50] ? sumx5_q + 51'sd65535 : sumx5_q;
  assign ty_d = sumy5_q[50] ? sumy5_q + 51'sd65535 : sumy5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      it6_q   <= it5_q;
      gate6_q <= gate5_q;
      col6_q  <= 35'(tx_d >>> 16);
      row6_q  <= 35'(ty_d >>> 16);
    end
  end

  // stage 7: bounds check and store address
  assign idx_ext = 26'(it6_q.index);
  assign pix_d   = 26'(row6_q[11:0]) * 26'(MAX_MASK_WIDTH) + 26'(col6_q[11:0]);

  always_comb begin
    if (it6_q.op == OP_MASK) begin
      look_d = {3'd0, it6_q.index} < 25'(MASK_DEPTH);
    end else begin
      look_d = gate6_q && !col6_q[34] && (col6_q < 35'(mw_lim))
               && !row6_q[34] && (row6_q < 35'(mh_lim));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it7_q   <= it6_q;
      look7_q <= look_d;
      addr7_q <= (it6_q.op == OP_MASK) ? idx_ext[AW-1:0] : pix_d[AW-1:0];
    end
  end

  // stage 8: mask store, one port
  always_ff @(posedge clk_i) begin
    if (en && vld7_q && look7_q && it7_q.op == OP_MASK) begin
      mask_mem_q[addr7_q] <= it7_q.value[7:0] == 8'hff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd8_q   <= mask_mem_q[addr7_q];
      it8_q   <= it7_q;
      look8_q <= look7_q;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q  <= it8_q.point_x;
      out_y_q  <= it8_q.point_y;
      out_z_q  <= it8_q.point_z;
      masked_q <= look8_q && rd8_q;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      vld3_q      <= 1'b0;
      vld4_q      <= 1'b0;
      dvld_q      <= '0;
      vld5_q      <= 1'b0;
      vld6_q      <= 1'b0;
      vld7_q      <= 1'b0;
      vld8_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld1_q      <= head_valid_i;
      vld2_q      <= vld1_q;
      vld3_q      <= vld2_q;
      vld4_q      <= vld3_q;
      dvld_q      <= {dvld_q[DIV_LAT-2:0], vld4_q};
      vld5_q      <= dvld_q[DIV_LAT-1];
      vld6_q      <= vld5_q;
      vld7_q      <= vld6_q;
      vld8_q      <= vld7_q;
      out_valid_q <= vld8_q && it8_q.op == OP_POINT;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.out_x  = out_x_q;
  assign out_o.out_y  = out_y_q;
  assign out_o.out_z  = out_z_q;
  assign out_o.masked = masked_q;

  // pipeline freezes while a result waits
  `LPCM_ASSERT_NEXT(a_stall_freezes, clk_i, rst_ni, out_valid_q && !out_o.ready, $stable(dvld_q) && $stable(vld8_q))
  // write words never produce a result
  `LPCM_ASSERT_NEXT(a_no_result_for_writes, clk_i, rst_ni, en && vld8_q && it8_q.op != OP_POINT, !out_valid_q)
  // transform writes reaching the back end are in range
  `LPCM_ASSERT_IMP(a_xform_in_range, clk_i, rst_ni, vld1_q && it1_q.op == OP_XFORM, it1_q.index < 22'(XFORM_ENTRIES))

endmodule

/* rtl/lidar_point_camera_mask_filter.sv */
// ----------------------------------------------------------------------------
// lidar_point_camera_mask_filter
// Projects lidar points into a camera mask and flags those on masked pixels.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the queue has room and delivers one result per
// point word, in order; most of the pipeline depth lies in the two pipelined
// dividers that form x/z and y/z. Mask and transform writes flow through the
// same pipeline and take effect in word order. The mask is a single-port
// one-bit-per-pixel store of MAX_MASK_WIDTH*MAX_MASK_HEIGHT entries with no
// clearing pass; every pixel in use must be written before points are
// classified. A four-word queue separates decode from the pipeline, and the
// pipeline stalls as a whole only while a finished result is not taken.
module lidar_point_camera_mask_filter #(
  parameter int MAX_MASK_WIDTH  = 2048,
  parameter int MAX_MASK_HEIGHT = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpcm_in_if.sink    in_i,
  lpcm_cfg_if.sink   cfg_i,
  lpcm_out_if.source out_o
);
  import lpcm_pkg::*;

  logic  push;
  logic  full;
  logic  head_valid;
  logic  pop;
  item_t front_item;
  item_t head_item;

  // decode front
  lpcm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .fifo_full_i (full),
    .push_o      (push),
    .item_o      (front_item)
  );

  // decoupling queue
  lpcm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  // projection back end
  lpcm_back #(
    .MAX_MASK_WIDTH  (MAX_MASK_WIDTH),
    .MAX_MASK_HEIGHT (MAX_MASK_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
